// ===== rtl/nqsc_pkg.sv =====
`default_nettype none
package nqsc_pkg;

  localparam int MAX_BOARD  = 16;
  localparam int COUNT_BITS = 24;

  localparam int COL_BITS  = 4;
  localparam int SIZE_BITS = 5;
  localparam int ROW_BITS  = $clog2(MAX_BOARD);
  localparam int N_BITS    = $clog2(MAX_BOARD + 1);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef logic [MAX_BOARD-1:0]  mask_t;
  typedef logic [COUNT_BITS-1:0] count_t;

  // occupancy seen by a row, and the columns still open to it
  typedef struct packed {
    mask_t cols;
    mask_t ldiag;
    mask_t rdiag;
    mask_t avail;
  } masks_t;

endpackage
`default_nettype wire

// ===== rtl/nqsc_query_if.sv =====
`default_nettype none
interface nqsc_query_if;
  logic                          valid;
  logic                          ready;
  logic [nqsc_pkg::COL_BITS-1:0] first_col;

  modport source (output valid, output first_col, input ready);
  modport sink   (input valid, input first_col, output ready);
endinterface
`default_nettype wire

// ===== rtl/nqsc_result_if.sv =====
`default_nettype none
interface nqsc_result_if;
  logic                            valid;
  logic                            ready;
  logic [nqsc_pkg::COUNT_BITS-1:0] solution_count;
  logic                            bad_column;

  modport source (output valid, output solution_count, output bad_column, input ready);
  modport sink   (input valid, input solution_count, input bad_column, output ready);
endinterface
`default_nettype wire

// ===== rtl/nqsc_cfg_if.sv =====
`default_nettype none
interface nqsc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [nqsc_pkg::SIZE_BITS-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/nqsc_cell.sv =====
`default_nettype none
// One board row: holds the attack masks it was entered with, the columns
// still untried, and the queen it placed last. Feeds its successor row.
module nqsc_cell (
  input  wire logic             clk,
  input  wire logic             load,
  input  wire logic             place,
  input  wire nqsc_pkg::mask_t  full,
  input  wire nqsc_pkg::masks_t load_in,
  output nqsc_pkg::masks_t      child,
  output logic                  empty
);

  nqsc_pkg::mask_t cols;
  nqsc_pkg::mask_t ldiag;
  nqsc_pkg::mask_t rdiag;
  nqsc_pkg::mask_t avail;
  nqsc_pkg::mask_t sel;
  nqsc_pkg::mask_t low_bit;

  assign low_bit = avail & (~avail + nqsc_pkg::mask_t'(1));
  assign empty   = (avail == '0);

  always_ff @(posedge clk) begin
    if (load) begin
      cols  <= load_in.cols;
      ldiag <= load_in.ldiag;
      rdiag <= load_in.rdiag;
      avail <= load_in.avail;
    end else if (place) begin
      sel   <= low_bit;
      avail <= avail & ~low_bit;
    end
  end

  always_comb begin
    child.cols  = cols | sel;
    child.ldiag = ((ldiag | sel) << 1) & full;
    child.rdiag = (rdiag | sel) >> 1;
    child.avail = ~(child.cols | child.ldiag | child.rdiag) & full;
  end

endmodule
`default_nettype wire

// ===== rtl/nqsc_ctrl.sv =====
`default_nettype none
// Search sequencer: walks the active row up and down the cell chain,
// counts complete placements and hands the result to the output register.
module nqsc_ctrl (
  input  wire logic                         clk,
  input  wire logic                         rst,
  nqsc_query_if.sink                        query,
  nqsc_result_if.source                     result,
  nqsc_cfg_if.sink                          cfg,
  input  wire logic [nqsc_pkg::MAX_BOARD-1:0] empties,
  output logic [nqsc_pkg::MAX_BOARD-1:0]    load_en,
  output logic [nqsc_pkg::MAX_BOARD-1:0]    place_en,
  output nqsc_pkg::mask_t                   full
);

  typedef enum logic [1:0] {IDLE, LOAD, TRY, FINISH} state_t;

  state_t                          state;
  logic [nqsc_pkg::SIZE_BITS-1:0]  board_size;
  logic [nqsc_pkg::N_BITS-1:0]     n_eff;
  logic [nqsc_pkg::N_BITS-1:0]     n_clamp;
  logic [nqsc_pkg::ROW_BITS-1:0]   row;
  nqsc_pkg::count_t                count;
  logic                            bad;
  nqsc_pkg::mask_t                 full_next;
  logic                            start;
  logic                            last_row;
  logic                            row_empty;

  assign cfg.ready   = 1'b1;
  assign query.ready = (state == IDLE);
  assign start       = query.valid && query.ready;

  always_comb begin
    if (int'(board_size) > nqsc_pkg::MAX_BOARD) begin
      n_clamp = nqsc_pkg::N_BITS'(nqsc_pkg::MAX_BOARD);
    end else begin
      n_clamp = nqsc_pkg::N_BITS'(board_size);
    end
    for (int i = 0; i < nqsc_pkg::MAX_BOARD; i++) begin
      full_next[i] = (i < int'(n_clamp));
    end
  end

  assign row_empty = empties[row];
  assign last_row  = (int'(row) + 1 >= int'(n_eff));

  always_comb begin
    load_en  = '0;
    place_en = '0;
    if (start) begin
      load_en[0] = 1'b1;
    end
    if (state == LOAD) begin
      load_en[row] = 1'b1;
    end
    if (state == TRY && !row_empty) begin
      place_en[row] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      board_size   <= nqsc_pkg::SIZE_BITS'(8);
      result.valid <= 1'b0;
      row          <= '0;
      count        <= '0;
      bad          <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        board_size <= cfg.data;
      end
      if (result.valid && result.ready && state != FINISH) begin
        result.valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (start) begin
            n_eff <= n_clamp;
            full  <= full_next;
            row   <= '0;
            count <= '0;
            if (int'(query.first_col) >= int'(n_clamp)) begin
              bad   <= 1'b1;
              state <= FINISH;
            end else begin
              bad   <= 1'b0;
              state <= TRY;
            end
          end
        end
        LOAD: begin
          state <= TRY;
        end
        TRY: begin
          if (row_empty) begin
            if (row == '0) begin
              state <= FINISH;
            end else begin
              row <= row - 1'b1;
            end
          end else if (last_row) begin
            // complete placement; stop outright once the count saturates
            count <= count + 1'b1;
            if (count == nqsc_pkg::COUNT_MAX - 1'b1) begin
              state <= FINISH;
            end
          end else begin
            row   <= row + 1'b1;
            state <= LOAD;
          end
        end
        FINISH: begin
          if (!result.valid || result.ready) begin
            result.valid          <= 1'b1;
            result.solution_count <= count;
            result.bad_column     <= bad;
            state                 <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/n_queens_solution_counter.sv =====
`default_nettype none
// N-queens solution counter. Each query transfer carries a first-row column;
// one result transfer returns the number of complete placements with that
// first-row queen (saturating) and a bad_column flag when the column is not
// below the board size. The board size (0..16, reset 8, larger values act
// as 16) is written on the cfg channel while the block is idle; the user is
// bound to this, and the block itself does not enforce it. The search runs
// over a chain of row cells: each try either places a column or backs up
// one row, and descending to the next row first places the queen, then
// loads the next cell. A bad column skips the search. A new query is taken
// while the previous result still waits on the result channel.
module n_queens_solution_counter (
  input  wire logic     clk,
  input  wire logic     rst,
  nqsc_query_if.sink    query,
  nqsc_result_if.source result,
  nqsc_cfg_if.sink      cfg
);

  logic [nqsc_pkg::MAX_BOARD-1:0] empties;
  logic [nqsc_pkg::MAX_BOARD-1:0] load_en;
  logic [nqsc_pkg::MAX_BOARD-1:0] place_en;
  nqsc_pkg::mask_t                full;
  nqsc_pkg::masks_t               child [nqsc_pkg::MAX_BOARD];
  nqsc_pkg::masks_t               seed;

  // row 0 is entered with only the requested column open
  always_comb begin
    seed.cols  = '0;
    seed.ldiag = '0;
    seed.rdiag = '0;
    seed.avail = nqsc_pkg::mask_t'(1) << query.first_col;
  end

  nqsc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .query    (query),
    .result   (result),
    .cfg      (cfg),
    .empties  (empties),
    .load_en  (load_en),
    .place_en (place_en),
    .full     (full)
  );

  for (genvar i = 0; i < nqsc_pkg::MAX_BOARD; i++) begin : g_row
    if (i == 0) begin : g_first
      nqsc_cell u_cell (
        .clk     (clk),
        .load    (load_en[i]),
        .place   (place_en[i]),
        .full    (full),
        .load_in (seed),
        .child   (child[i]),
        .empty   (empties[i])
      );
    end else begin : g_next
      nqsc_cell u_cell (
        .clk     (clk),
        .load    (load_en[i]),
        .place   (place_en[i]),
        .full    (full),
        .load_in (child[i-1]),
        .child   (child[i]),
        .empty   (empties[i])
      );
    end
  end

endmodule
`default_nettype wire

// ===== rtl/nqsc_checker.sv =====
`default_nettype none
module nqsc_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            in_valid,
  input wire logic                            in_ready,
  input wire logic                            out_valid,
  input wire logic                            out_ready,
  input wire logic [nqsc_pkg::COUNT_BITS-1:0] solution_count,
  input wire logic                            bad_column
);

  logic [1:0] outstanding;
  logic       in_fire;
  logic       out_fire;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else begin
      outstanding <= outstanding + {1'b0, in_fire} - {1'b0, out_fire};
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(solution_count) && $stable(bad_column))
    else $error("result changed while stalled");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_column |-> solution_count == '0)
    else $error("bad column with nonzero count");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !in_ready)
    else $error("query taken while a search runs");

  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> outstanding != 2'd0)
    else $error("result without a query");

  a_bound: assert property (@(posedge clk) disable iff (rst)
    outstanding != 2'd3)
    else $error("too many queries in flight");

endmodule

bind n_queens_solution_counter nqsc_checker u_nqsc_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (query.valid),
  .in_ready       (query.ready),
  .out_valid      (result.valid),
  .out_ready      (result.ready),
  .solution_count (result.solution_count),
  .bad_column     (result.bad_column)
);
`default_nettype wire

// ===== verif/tb_n_queens_solution_counter.sv =====
`timescale 1ns / 1ps

module tb_n_queens_solution_counter;

  localparam int IDLE_LIMIT        = 2_000_000;
  localparam int RANDOM_ITEMS      = 75;
  localparam int LONG_HOLD_AT      = 30;
  localparam int LONG_HOLD_CYCLES  = 2500;
  localparam int DRAIN_CYCLES      = 20;

  typedef struct packed {
    nqsc_pkg::count_t solution_count;
    logic             bad_column;
  } outcome_t;

  typedef enum logic [1:0] {RX_FREE, RX_HALF, RX_SPARSE, RX_MOSTLY} rx_mode_t;

  logic clk;
  logic rst;

  nqsc_query_if  query_ch ();
  nqsc_result_if result_ch ();
  nqsc_cfg_if    cfg_ch ();

  n_queens_solution_counter dut (
    .clk    (clk),
    .rst    (rst),
    .query  (query_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  logic [nqsc_pkg::COL_BITS-1:0]  pending_cols[$];
  outcome_t                       expected_outcomes[$];
  logic [nqsc_pkg::SIZE_BITS-1:0] board_size_reg = 5'd8;
  outcome_t                       want;
  logic                           query_taken = 1'b0;
  int                             errors = 0;
  int                             results_seen = 0;
  int                             idle_cycles = 0;

  int       burst_left = 1;
  int       gap_left = 0;
  int       hold_left = 0;
  logic     hold_done = 1'b0;
  rx_mode_t rx_mode = RX_FREE;
  int       mode_left = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Depth-first walk over rows 1..n-1 with occupancy masks, row 0 fixed at col.
  function automatic outcome_t count_placements(
      logic [nqsc_pkg::SIZE_BITS-1:0] size_reg,
      logic [nqsc_pkg::COL_BITS-1:0]  col);
    outcome_t         r;
    int               n;
    int               row;
    nqsc_pkg::mask_t  full;
    nqsc_pkg::mask_t  pick;
    nqsc_pkg::mask_t  cols[nqsc_pkg::MAX_BOARD+1];
    nqsc_pkg::mask_t  ldiag[nqsc_pkg::MAX_BOARD+1];
    nqsc_pkg::mask_t  rdiag[nqsc_pkg::MAX_BOARD+1];
    nqsc_pkg::mask_t  avail[nqsc_pkg::MAX_BOARD+1];
    nqsc_pkg::count_t cnt;
    n = (size_reg > nqsc_pkg::MAX_BOARD) ? nqsc_pkg::MAX_BOARD : int'(size_reg);
    r.solution_count = '0;
    r.bad_column = 1'b0;
    if (int'(col) >= n) begin
      r.bad_column = 1'b1;
      return r;
    end
    if (n == 1) begin
      r.solution_count = nqsc_pkg::count_t'(1);
      return r;
    end
    full = (n == nqsc_pkg::MAX_BOARD) ? '1 : nqsc_pkg::mask_t'((1 << n) - 1);
    pick = nqsc_pkg::mask_t'(1) << col;
    cols[1]  = pick;
    ldiag[1] = (pick << 1) & full;
    rdiag[1] = pick >> 1;
    avail[1] = ~(cols[1] | ldiag[1] | rdiag[1]) & full;
    row = 1;
    cnt = '0;
    while (row >= 1 && cnt != nqsc_pkg::COUNT_MAX) begin
      if (avail[row] == '0) begin
        row--;
      end else begin
        pick = avail[row] & (~avail[row] + nqsc_pkg::mask_t'(1));
        avail[row] &= ~pick;
        if (row + 1 >= n) begin
          cnt++;
        end else begin
          cols[row+1]  = cols[row] | pick;
          ldiag[row+1] = ((ldiag[row] | pick) << 1) & full;
          rdiag[row+1] = (rdiag[row] | pick) >> 1;
          avail[row+1] = ~(cols[row+1] | ldiag[row+1] | rdiag[row+1]) & full;
          row++;
        end
      end
    end
    r.solution_count = cnt;
    return r;
  endfunction

  // Query driver: bursts of random length with random gaps.
  always @(negedge clk) begin : query_driver
    logic                          nv;
    logic [nqsc_pkg::COL_BITS-1:0] nc;
    nv = query_ch.valid;
    nc = query_ch.first_col;
    if (rst) begin
      nv = 1'b0;
    end else if (!query_ch.valid || query_taken) begin
      nv = 1'b0;
      if (gap_left != 0) begin
        gap_left--;
      end else if (pending_cols.size() != 0) begin
        nv = 1'b1;
        nc = pending_cols.pop_front();
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
        end else begin
          burst_left--;
        end
      end
    end
    query_ch.valid <= nv;
    query_ch.first_col <= nc;
  end

  // Result receiver: random stall pattern, plus one long hold-off to back up the block.
  always @(negedge clk) begin : result_receiver
    logic rdy;
    rdy = 1'b1;
    if (!hold_done && results_seen >= LONG_HOLD_AT) begin
      hold_left = LONG_HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left != 0) begin
      hold_left--;
      rdy = 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 200);
      end else begin
        mode_left--;
      end
      case (rx_mode)
        RX_FREE:   rdy = 1'b1;
        RX_HALF:   rdy = ($urandom_range(0, 1) == 1);
        RX_SPARSE: rdy = ($urandom_range(0, 3) == 0);
        default:   rdy = ($urandom_range(0, 3) != 0);
      endcase
    end
    result_ch.ready <= rdy;
  end

  always @(posedge clk) begin
    query_taken <= !rst && query_ch.valid && query_ch.ready;
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        board_size_reg = cfg_ch.data;
      end
      if (query_ch.valid && query_ch.ready) begin
        expected_outcomes.push_back(count_placements(board_size_reg, query_ch.first_col));
      end
      if (result_ch.valid && result_ch.ready) begin
        results_seen++;
        if (expected_outcomes.size() == 0) begin
          $error("unexpected result transfer: solution_count=%0d bad_column=%0b",
                 result_ch.solution_count, result_ch.bad_column);
          errors++;
        end else begin
          want = expected_outcomes.pop_front();
          if (result_ch.solution_count !== want.solution_count) begin
            $error("solution_count: expected %0d, actual %0d",
                   want.solution_count, result_ch.solution_count);
            errors++;
          end
          if (result_ch.bad_column !== want.bad_column) begin
            $error("bad_column: expected %0b, actual %0b",
                   want.bad_column, result_ch.bad_column);
            errors++;
          end
        end
      end
    end
  end

  // Watchdog on cycles with no transfer on any channel.
  always @(posedge clk) begin
    if ((query_ch.valid && query_ch.ready) || (result_ch.valid && result_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic wait_drained();
    while (pending_cols.size() != 0 || query_ch.valid || expected_outcomes.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_board_size(input logic [nqsc_pkg::SIZE_BITS-1:0] value);
    wait_drained();
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin : stimulus
    logic [nqsc_pkg::SIZE_BITS-1:0] size;
    logic [nqsc_pkg::COL_BITS-1:0]  col;
    int                             count;
    int                             random_items;
    int                             pick;
    rst = 1'b1;
    query_ch.valid = 1'b0;
    query_ch.first_col = '0;
    result_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset board size, including columns past the edge
    pending_cols = '{4'd0, 4'd7, 4'd8, 4'd15};
    write_board_size(5'd1);
    pending_cols = '{4'd0, 4'd1, 4'd15};
    // boards of two and three have no placement
    write_board_size(5'd2);
    pending_cols = '{4'd0, 4'd1};
    write_board_size(5'd3);
    pending_cols = '{4'd0, 4'd1, 4'd2};
    // size zero: every column is out of range
    write_board_size(5'd0);
    pending_cols = '{4'd0, 4'd15};
    // largest and over-range sizes are only written; a full search there is far too long
    write_board_size(5'd16);
    write_board_size(5'd31);
    write_board_size(5'd4);
    pending_cols = '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4};
    write_board_size(5'd10);
    pending_cols = '{4'd9};
    write_board_size(5'd11);
    pending_cols = '{4'd10};

    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        size = nqsc_pkg::SIZE_BITS'($urandom_range(0, 3));
      end else if (pick < 17) begin
        size = 5'd10;
      end else begin
        size = nqsc_pkg::SIZE_BITS'($urandom_range(4, 9));
      end
      write_board_size(size);
      count = (size == 5'd10) ? $urandom_range(1, 2) : $urandom_range(4, 15);
      repeat (count) begin
        if (size == 5'd0 || $urandom_range(0, 9) == 0) begin
          col = nqsc_pkg::COL_BITS'($urandom_range(0, 15));
        end else begin
          col = nqsc_pkg::COL_BITS'($urandom_range(0, int'(size) - 1));
        end
        pending_cols.push_back(col);
      end
      random_items += count;
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
